// ----- rtl/cdn_pkg.sv -----
// shared types, constants and microcode program of the calendar countdown
package cdn_pkg;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 56;
    localparam int PC_W     = 4;
    localparam int ACC_W    = 40;
    localparam int QUO_W    = 32;
    localparam int REM_W    = 12;
    localparam int HQ_W     = 21;

    localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
    localparam logic [8:0]  YEAR_DAYS    = 9'd365;
    localparam logic [16:0] DAY_SECS     = 17'd86400;
    localparam logic [11:0] HOUR_SECS    = 12'd3600;
    localparam logic [11:0] MIN_SECS     = 12'd60;
    localparam logic [31:0] THRESH_RESET = 32'd86400;

    // 1970 taken modulo 4, 100 and 400
    localparam logic [1:0] M4_INIT   = 2'd2;
    localparam logic [6:0] M100_INIT = 7'd70;
    localparam logic [8:0] M400_INIT = 9'd370;
    localparam logic [6:0] M100_LAST = 7'd99;
    localparam logic [8:0] M400_LAST = 9'd399;

    localparam logic [3:0] MON_LAST_IDX = 4'd11;
    localparam logic [3:0] MON_MAR_IDX  = 4'd2;
    localparam logic [3:0] MON_MAX      = 4'd12;

    // reciprocals: x / 3600 as (x >> 4) / 225, x / 60 as (x >> 2) / 15
    localparam logic [28:0] HOUR_RECIP = 29'd305419897;  // ceil(2^36 / 225)
    localparam int          HP_SHIFT   = 36;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;       // ceil(2^14 / 15)
    localparam int          MP_SHIFT   = 14;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_YEAR,
        OP_MONTH,
        OP_MUL_DAY,
        OP_MUL_HOUR,
        OP_MUL_MIN,
        OP_ADD_SEC,
        OP_SUB_NOW,
        OP_CLAMP,
        OP_DIV_H,
        OP_SET_M,
        OP_DIV_M,
        OP_SET_S,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_INPUT,
        COND_YEAR_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
        logic             wrap;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic year_more;
        logic out_busy;
    } stat_t;

    // program addresses that are jumped to
    localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
    localparam logic [PC_W-1:0] PC_YEAR  = 4'd1;
    localparam logic [PC_W-1:0] PC_EMIT  = 4'd13;

    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            default: d = 9'd334;
        endcase
        return d;
    endfunction

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            4'd0:    w = '{OP_WAIT,     COND_NO_INPUT,  PC_WAIT,  1'b0};
            4'd1:    w = '{OP_YEAR,     COND_YEAR_MORE, PC_YEAR,  1'b0};
            4'd2:    w = '{OP_MONTH,    COND_NEVER,     PC_WAIT,  1'b0};
            4'd3:    w = '{OP_MUL_DAY,  COND_NEVER,     PC_WAIT,  1'b0};
            4'd4:    w = '{OP_MUL_HOUR, COND_NEVER,     PC_WAIT,  1'b0};
            4'd5:    w = '{OP_MUL_MIN,  COND_NEVER,     PC_WAIT,  1'b0};
            4'd6:    w = '{OP_ADD_SEC,  COND_NEVER,     PC_WAIT,  1'b0};
            4'd7:    w = '{OP_SUB_NOW,  COND_NEVER,     PC_WAIT,  1'b0};
            4'd8:    w = '{OP_CLAMP,    COND_NEVER,     PC_WAIT,  1'b0};
            4'd9:    w = '{OP_DIV_H,    COND_NEVER,     PC_WAIT,  1'b0};
            4'd10:   w = '{OP_SET_M,    COND_NEVER,     PC_WAIT,  1'b0};
            4'd11:   w = '{OP_DIV_M,    COND_NEVER,     PC_WAIT,  1'b0};
            4'd12:   w = '{OP_SET_S,    COND_NEVER,     PC_WAIT,  1'b0};
            4'd13:   w = '{OP_EMIT,     COND_OUT_BUSY,  PC_EMIT,  1'b1};
            default: w = '{OP_WAIT,     COND_NEVER,     PC_WAIT,  1'b1};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/cdn_sequencer.sv -----
// microcode sequencer: step counter, program table and conditional jumps
module cdn_sequencer (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cdn_pkg::stat_t         stat_i,
    output cdn_pkg::op_t           op_o
);
    import cdn_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ucode_t          word;
    logic            take;

    always_comb begin
        word = ucode_rom(pc_reg);
        case (word.cond)
            COND_NEVER:     take = 1'b0;
            COND_NO_INPUT:  take = !stat_i.in_valid;
            COND_YEAR_MORE: take = stat_i.year_more;
            COND_OUT_BUSY:  take = stat_i.out_busy;
            default:        take = 1'b0;
        endcase
        if (take) begin
            pc_next = word.target;
        end else if (word.wrap) begin
            pc_next = PC_WAIT;
        end else begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign op_o = word.op;

endmodule

// ----- rtl/cdn_datapath.sv -----
// datapath: year walk, day and second accumulation, reciprocal divides, output word
module cdn_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cdn_pkg::op_t                    op_i,
    input  logic [31:0]                     thresh_i,
    output cdn_pkg::stat_t                  stat_o,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cdn_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cdn_pkg::M_DATA_W-1:0]    m_tdata
);
    import cdn_pkg::*;

    // captured input word
    logic [11:0] year_reg, year_next;
    logic [3:0]  mon_reg, mon_next;
    logic [4:0]  daym1_reg, daym1_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic [31:0] now_reg, now_next;

    // year walk
    logic [11:0] yr_reg, yr_next;
    logic [1:0]  m4_reg, m4_next;
    logic [6:0]  m100_reg, m100_next;
    logic [8:0]  m400_reg, m400_next;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] prod_reg, prod_next;

    // split of the remaining time
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [HQ_W-1:0]  hq_reg, hq_next;
    logic [REM_W-1:0] rem_reg, rem_next;

    // result fields
    logic [32:0] diff_reg, diff_next;
    logic        soon_reg, soon_next;
    logic        passed_reg, passed_next;
    logic [7:0]  hrs_reg, hrs_next;
    logic [5:0]  mins_reg, mins_next;
    logic [5:0]  secs_reg, secs_next;

    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                m_valid_reg, m_valid_next;

    logic [11:0] in_year;
    logic [3:0]  in_mon;
    logic [4:0]  in_day;
    logic        leap;
    logic        out_busy;
    logic        neg;
    logic        big;
    logic [ACC_W-1:0] day_prod;
    logic [ACC_W-1:0] hour_prod;
    logic [ACC_W-1:0] min_prod;
    logic [56:0]      hq_prod;
    logic [QUO_W-1:0] h_rem;
    logic [20:0]      mq_prod;
    logic [REM_W-1:0] m_rem;

    assign in_year = s_tdata[11:0];
    assign in_mon  = s_tdata[15:12];
    assign in_day  = s_tdata[20:16];

    assign leap      = (m400_reg == '0) || ((m4_reg == '0) && (m100_reg != '0));
    assign out_busy  = m_valid_reg && !m_tready;
    assign neg       = acc_reg[ACC_W-1];
    assign big       = !neg && (acc_reg[ACC_W-2:32] != '0);
    assign day_prod  = ACC_W'(acc_reg[19:0]) * ACC_W'(DAY_SECS);
    assign hour_prod = ACC_W'(hour_reg) * ACC_W'(HOUR_SECS);
    assign min_prod  = ACC_W'(min_reg) * ACC_W'(MIN_SECS);

    // reciprocal divides, exact over the full operand range
    assign hq_prod = 57'(quo_reg[QUO_W-1:4]) * 57'(HOUR_RECIP);
    assign h_rem   = quo_reg - QUO_W'(hq_reg) * QUO_W'(HOUR_SECS);
    assign mq_prod = 21'(rem_reg[REM_W-1:2]) * 21'(MIN_RECIP);
    assign m_rem   = rem_reg - REM_W'(mins_reg) * REM_W'(MIN_SECS);

    always_comb begin
        year_next    = year_reg;
        mon_next     = mon_reg;
        daym1_next   = daym1_reg;
        hour_next    = hour_reg;
        min_next     = min_reg;
        sec_next     = sec_reg;
        now_next     = now_reg;
        yr_next      = yr_reg;
        m4_next      = m4_reg;
        m100_next    = m100_reg;
        m400_next    = m400_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        quo_next     = quo_reg;
        hq_next      = hq_reg;
        rem_next     = rem_reg;
        diff_next    = diff_reg;
        soon_next    = soon_reg;
        passed_next  = passed_reg;
        hrs_next     = hrs_reg;
        mins_next    = mins_reg;
        secs_next    = secs_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;

        case (op_i)
            OP_WAIT: begin
                if (s_tvalid) begin
                    year_next  = (in_year < EPOCH_YEAR) ? EPOCH_YEAR : in_year;
                    if (in_mon == '0) begin
                        mon_next = '0;
                    end else if (in_mon > MON_MAX) begin
                        mon_next = MON_LAST_IDX;
                    end else begin
                        mon_next = in_mon - 4'd1;
                    end
                    daym1_next = (in_day == '0) ? '0 : in_day - 5'd1;
                    hour_next  = s_tdata[25:21];
                    min_next   = s_tdata[31:26];
                    sec_next   = s_tdata[37:32];
                    now_next   = s_tdata[69:38];
                    yr_next    = EPOCH_YEAR;
                    m4_next    = M4_INIT;
                    m100_next  = M100_INIT;
                    m400_next  = M400_INIT;
                    acc_next   = '0;
                end
            end
            OP_YEAR: begin
                if (yr_reg < year_reg) begin
                    acc_next  = acc_reg + ACC_W'(YEAR_DAYS) + ACC_W'(leap);
                    yr_next   = yr_reg + 12'd1;
                    m4_next   = m4_reg + 2'd1;
                    m100_next = (m100_reg == M100_LAST) ? '0 : m100_reg + 7'd1;
                    m400_next = (m400_reg == M400_LAST) ? '0 : m400_reg + 9'd1;
                end
            end
            OP_MONTH: begin
                // counters now sit on the target year, so leap is its own
                acc_next = acc_reg + ACC_W'(month_start(mon_reg)) + ACC_W'(daym1_reg)
                         + ACC_W'(leap && (mon_reg >= MON_MAR_IDX));
            end
            OP_MUL_DAY: begin
                prod_next = day_prod;
                acc_next  = '0;
            end
            OP_MUL_HOUR: begin
                acc_next  = acc_reg + prod_reg;
                prod_next = hour_prod;
            end
            OP_MUL_MIN: begin
                acc_next  = acc_reg + prod_reg;
                prod_next = min_prod;
            end
            OP_ADD_SEC: begin
                acc_next = acc_reg + prod_reg + ACC_W'(sec_reg);
            end
            OP_SUB_NOW: begin
                acc_next = acc_reg - ACC_W'(now_reg);
            end
            OP_CLAMP: begin
                passed_next = neg;
                if (neg) begin
                    diff_next = acc_reg[32:0];
                    soon_next = 1'b1;
                    quo_next  = '0;
                end else if (big) begin
                    diff_next = {1'b0, {32{1'b1}}};
                    soon_next = (thresh_i == {32{1'b1}});
                    quo_next  = '1;
                end else begin
                    diff_next = {1'b0, acc_reg[31:0]};
                    soon_next = (acc_reg[31:0] <= thresh_i);
                    quo_next  = acc_reg[31:0];
                end
            end
            OP_DIV_H: begin
                hq_next = hq_prod[HP_SHIFT +: HQ_W];
            end
            OP_SET_M: begin
                hrs_next = (hq_reg[HQ_W-1:8] != '0) ? 8'hFF : hq_reg[7:0];
                rem_next = h_rem[REM_W-1:0];
            end
            OP_DIV_M: begin
                mins_next = mq_prod[MP_SHIFT +: 6];
            end
            OP_SET_S: begin
                secs_next = m_rem[5:0];
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    m_data_next  = {1'b0, secs_reg, mins_reg, hrs_reg,
                                    passed_reg, soon_reg, diff_reg};
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        year_reg   <= year_next;
        mon_reg    <= mon_next;
        daym1_reg  <= daym1_next;
        hour_reg   <= hour_next;
        min_reg    <= min_next;
        sec_reg    <= sec_next;
        now_reg    <= now_next;
        yr_reg     <= yr_next;
        m4_reg     <= m4_next;
        m100_reg   <= m100_next;
        m400_reg   <= m400_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        quo_reg    <= quo_next;
        hq_reg     <= hq_next;
        rem_reg    <= rem_next;
        diff_reg   <= diff_next;
        soon_reg   <= soon_next;
        passed_reg <= passed_next;
        hrs_reg    <= hrs_next;
        mins_reg   <= mins_next;
        secs_reg   <= secs_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign stat_o.in_valid  = s_tvalid;
    assign stat_o.year_more = ({1'b0, yr_reg} + 13'd1) < {1'b0, year_reg};
    assign stat_o.out_busy  = out_busy;

    assign s_tready = (op_i == OP_WAIT);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- rtl/calendar_countdown.sv -----
// top level of the calendar countdown: threshold register, sequencer and datapath
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  s_      | in        | s_tvalid / s_tready | target date, time and now, 72-bit word
//  cfg_    | in        | cfg_valid/cfg_ready | soon_threshold, 32 bits
//  m_      | out       | m_tvalid / m_tready | signed difference, flags and h/m/s split
//
// one word at a time; year clamped to at least 1970; the year walk adds one year
// a cycle, seven steps build and clamp the difference, four split it by reciprocal
// multiplies
// s_tready is high only while the sequencer sits on its wait step; a result held in
// the output register does not block the next word, only the following result
// synchronous active-low reset returns the sequencer to wait, empties the output
// register and sets the threshold to 86400; cfg_ready is always high
module calendar_countdown (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [11:0] target_year, [15:12] target_month, [20:16] target_day,
    // [25:21] target_hour, [31:26] target_minute, [37:32] target_second,
    // [69:38] now_seconds, [71:70] zero
    input  logic [cdn_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [31:0]                     cfg_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [32:0] seconds_left, [33] is_soon, [34] has_passed, [42:35] hours_left,
    // [48:43] minutes_left, [54:49] seconds_part, [55] zero
    output logic [cdn_pkg::M_DATA_W-1:0]    m_tdata
);
    import cdn_pkg::*;

    logic [31:0] thresh_reg;
    logic [31:0] thresh_next;
    op_t         op;
    stat_t       stat;

    // the user must change the threshold only between words; the block does not enforce it
    assign cfg_ready   = 1'b1;
    assign thresh_next = (cfg_valid && cfg_ready) ? cfg_data : thresh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else begin
            thresh_reg <= thresh_next;
        end
    end

    // program counter and microcode table
    cdn_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat_i  (stat),
        .op_o    (op)
    );

    // arithmetic, divider and output register
    cdn_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_i     (op),
        .thresh_i (thresh_reg),
        .stat_o   (stat),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- rtl/cdn_checker.sv -----
// port-level checks for the calendar countdown, bound to the top level
module cdn_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [cdn_pkg::M_DATA_W-1:0]    m_tdata
);
    import cdn_pkg::*;

    // a waiting result is not withdrawn
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // one word in flight: the engine is busy right after taking a word
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while busy");

    // passed flag follows the sign of the difference
    a_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[34] == m_tdata[32]))
        else $error("passed flag disagrees with sign");

    // a passed target reads as soon with a zero split
    a_passed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34] |-> m_tdata[33] && (m_tdata[54:35] == '0))
        else $error("passed target with non-zero split");

    // minutes and seconds stay below sixty
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[48:43] < 6'd60) && (m_tdata[54:49] < 6'd60))
        else $error("minute or second part out of range");

endmodule

bind calendar_countdown cdn_checker u_cdn_checker (.*);
